### hw/rtl/prim_mst_pkg.sv
// ----------------------------------------------------------------------------
// prim_mst_pkg
// Shared field widths, command codes, register indexes and sequencer states
// of the minimum spanning tree engine.
// ----------------------------------------------------------------------------
package prim_mst_pkg;

	// fixed field widths of the command and result channels
	localparam int OPCODE_W    = 2;
	localparam int VERTEX_W    = 4;
	localparam int WEIGHT_W    = 16;
	localparam int COUNT_W     = 5;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 5;

	// command codes
	typedef enum logic [OPCODE_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_RUN   = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_COUNT = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_START_VERTEX = 1'b1;

	// configuration reset values
	localparam logic [COUNT_W-1:0]  VERTEX_COUNT_RESET = 5'd16;
	localparam logic [VERTEX_W-1:0] START_VERTEX_RESET = 4'd1;

	// sequencer states
	typedef enum logic [10:0] {
		ST_IDLE     = 11'b000_0000_0001,
		ST_INIT     = 11'b000_0000_0010,
		ST_INIT_END = 11'b000_0000_0100,
		ST_SCAN     = 11'b000_0000_1000,
		ST_SCAN_END = 11'b000_0001_0000,
		ST_EMIT     = 11'b000_0010_0000,
		ST_UPD      = 11'b000_0100_0000,
		ST_UPD_END  = 11'b000_1000_0000,
		ST_CLR      = 11'b001_0000_0000,
		ST_WR_RD    = 11'b010_0000_0000,
		ST_WR_WR    = 11'b100_0000_0000
	} state_t;

endpackage

### hw/rtl/prim_minimum_spanning_tree.sv
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree
// Prim minimum spanning tree engine over an adjacency matrix held in a
// synchronous memory, with a second memory for the per-vertex best edge.
// ----------------------------------------------------------------------------
// An add command writes its edge when accepted; the matrix is kept symmetric
// by storing each vertex pair once, at row min(a,b) and column max(a,b). A
// clear command, and the pass that follows reset, sweeps every entry of the
// edge memory one entry per cycle, with no command taken meanwhile. A compute
// command first seeds the best-edge memory from the start row, then for each
// tree edge scans the best-edge memory for the cheapest crossing edge, posts
// the result and relaxes the neighbors of the new vertex through the edge
// memory read port; after the last result the matrix is swept clear and the
// tree edges are written back, one vertex at a time. A result is posted only
// when the result register is free.
module prim_minimum_spanning_tree #(
	parameter int MAX_VERTICES = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration writes
	input  logic                                 cfg_we,
	input  logic [prim_mst_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [prim_mst_pkg::CFG_DATA_W-1:0]  cfg_data,
	// command channel
	input  logic                                 cmd_valid,
	output logic                                 cmd_ready,
	input  logic [prim_mst_pkg::OPCODE_W-1:0]    opcode,
	input  logic [prim_mst_pkg::VERTEX_W-1:0]    vertex_a,
	input  logic [prim_mst_pkg::VERTEX_W-1:0]    vertex_b,
	input  logic [prim_mst_pkg::WEIGHT_W-1:0]    weight,
	// result channel
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output logic [prim_mst_pkg::VERTEX_W-1:0]    from_vertex,
	output logic [prim_mst_pkg::VERTEX_W-1:0]    to_vertex,
	output logic [prim_mst_pkg::WEIGHT_W-1:0]    edge_weight,
	output logic                                 disconnected,
	output logic                                 last
);
	import prim_mst_pkg::*;

	localparam int VW    = $clog2(MAX_VERTICES);
	localparam int AW    = 2 * VW;
	localparam int DEPTH = 1 << AW;
	localparam int EW    = WEIGHT_W + 1;
	localparam int BW    = EW + VW;

	// sequencer and run state
	state_t                state_q;
	state_t                state_s1;
	logic [COUNT_W-1:0]    vertex_count_q;
	logic [VERTEX_W-1:0]   start_vertex_q;
	logic [VW-1:0]         nm1_q;
	logic [VW-1:0]         s_q;
	logic [VW-1:0]         cnt_q;
	logic [VW-1:0]         v_s1;
	logic [VW-1:0]         joined_q;
	logic [AW-1:0]         clr_q;
	logic                  rewrite_q;
	logic [MAX_VERTICES-1:0] in_tree_q;

	// cheapest crossing edge found by the scan
	logic                  found_q;
	logic [VW-1:0]         pick_q;
	logic [VW-1:0]         pparent_q;
	logic [WEIGHT_W-1:0]   pw_q;

	// result register
	logic                  res_valid_q;
	logic [VERTEX_W-1:0]   from_q;
	logic [VERTEX_W-1:0]   to_q;
	logic [WEIGHT_W-1:0]   weight_q;
	logic                  disc_q;
	logic                  last_q;

	// memories
	logic [EW-1:0]         edge_mem [DEPTH];
	logic [EW-1:0]         edge_rd;
	logic                  edge_we;
	logic [AW-1:0]         edge_wa;
	logic [AW-1:0]         edge_ra;
	logic [EW-1:0]         edge_wd;

	logic [BW-1:0]         best_mem [MAX_VERTICES];
	logic [BW-1:0]         best_rd;
	logic                  best_we;
	logic [VW-1:0]         best_wa;
	logic [BW-1:0]         best_wd;

	// misc combinational
	logic                  cmd_fire;
	opcode_t               cmd_op;
	logic                  add_ok;
	logic [VW-1:0]         nm1_c;
	logic [VW-1:0]         s_c;
	logic                  e_present;
	logic [WEIGHT_W-1:0]   e_weight;
	logic                  b_present;
	logic [WEIGHT_W-1:0]   b_weight;
	logic [VW-1:0]         b_parent;
	logic                  scan_take;
	logic                  upd_take;
	logic                  last_c;
	logic                  res_free;

	// address of a vertex pair, lower index as row
	function automatic logic [AW-1:0] pair_addr(input logic [VW-1:0] x,
	                                            input logic [VW-1:0] y);
		logic [AW-1:0] a;
		if (x < y) a = {x, y};
		else       a = {y, x};
		return a;
	endfunction

	// handshake
	assign cmd_ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd_valid && cmd_ready;
	assign cmd_op    = opcode_t'(opcode);
	assign add_ok    = (int'(vertex_a) < MAX_VERTICES) && (int'(vertex_b) < MAX_VERTICES);
	assign res_free  = !res_valid_q || res_ready;

	// clamped vertex count and start vertex
	always_comb begin
		if (vertex_count_q < COUNT_W'(2)) begin
			nm1_c = VW'(1);
		end else if (int'(vertex_count_q) > MAX_VERTICES) begin
			nm1_c = VW'(MAX_VERTICES - 1);
		end else begin
			nm1_c = VW'(vertex_count_q - COUNT_W'(1));
		end
		if (int'(start_vertex_q) > int'(nm1_c)) s_c = nm1_c;
		else                                    s_c = VW'(start_vertex_q);
	end

	// fields of the registered read data
	assign e_present = edge_rd[EW-1];
	assign e_weight  = edge_rd[WEIGHT_W-1:0];
	assign b_present = best_rd[BW-1];
	assign b_weight  = best_rd[BW-2 -: WEIGHT_W];
	assign b_parent  = best_rd[VW-1:0];

	// stage one decisions for scan and relax
	assign scan_take = (state_s1 == ST_SCAN) && !in_tree_q[v_s1] && b_present &&
	                   (!found_q || (b_weight < pw_q));
	assign upd_take  = (state_s1 == ST_UPD) && !in_tree_q[v_s1] && e_present &&
	                   (!b_present || (e_weight < b_weight) ||
	                    ((e_weight == b_weight) && (pick_q < b_parent)));
	assign last_c    = (VW'(joined_q + VW'(1)) == nm1_q);

	// edge memory ports
	always_comb begin
		edge_ra = (state_q == ST_UPD) ? pair_addr(pick_q, cnt_q) : pair_addr(s_q, cnt_q);
		edge_we = 1'b0;
		edge_wa = pair_addr(VW'(vertex_a), VW'(vertex_b));
		edge_wd = {1'b1, weight};
		if (cmd_fire && (cmd_op == OP_ADD) && add_ok) begin
			edge_we = 1'b1;
		end else if (state_q == ST_CLR) begin
			edge_we = 1'b1;
			edge_wa = clr_q;
			edge_wd = '0;
		end else if ((state_q == ST_WR_WR) && in_tree_q[cnt_q] && (cnt_q != s_q)) begin
			edge_we = 1'b1;
			edge_wa = pair_addr(b_parent, cnt_q);
			edge_wd = {1'b1, b_weight};
		end
	end

	always_ff @(posedge clk) begin
		if (edge_we) edge_mem[edge_wa] <= edge_wd;
		edge_rd <= edge_mem[edge_ra];
	end

	// best-edge memory ports
	always_comb begin
		best_we = 1'b0;
		best_wa = v_s1;
		best_wd = {edge_rd, s_q};
		if (state_s1 == ST_INIT) begin
			best_we = 1'b1;
		end else if (upd_take) begin
			best_we = 1'b1;
			best_wd = {edge_rd, pick_q};
		end
	end

	always_ff @(posedge clk) begin
		if (best_we) best_mem[best_wa] <= best_wd;
		best_rd <= best_mem[cnt_q];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VERTEX_COUNT_RESET;
			start_vertex_q <= START_VERTEX_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VERTEX_COUNT: vertex_count_q <= cfg_data[COUNT_W-1:0];
				REG_START_VERTEX: start_vertex_q <= cfg_data[VERTEX_W-1:0];
				default: ;
			endcase
		end
	end

	// stage one tracks what the read issued last cycle belongs to
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_s1 <= ST_IDLE;
			v_s1     <= '0;
		end else begin
			state_s1 <= state_q;
			v_s1     <= cnt_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			rewrite_q   <= 1'b0;
			cnt_q       <= '0;
			nm1_q       <= '0;
			s_q         <= '0;
			joined_q    <= '0;
			in_tree_q   <= '0;
			found_q     <= 1'b0;
			pick_q      <= '0;
			pparent_q   <= '0;
			pw_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// result transfer frees the register unless a new result is posted
			if (res_valid_q && res_ready && (state_q != ST_EMIT)) res_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						case (cmd_op)
							OP_CLEAR: begin
								state_q   <= ST_CLR;
								clr_q     <= '0;
								rewrite_q <= 1'b0;
							end
							OP_RUN: begin
								nm1_q     <= nm1_c;
								s_q       <= s_c;
								in_tree_q <= MAX_VERTICES'(1) << s_c;
								joined_q  <= '0;
								cnt_q     <= '0;
								state_q   <= ST_INIT;
							end
							OP_ADD: ;
							OP_NONE: ;
							default: ;
						endcase
					end
				end
				// seed best edges from the start row
				ST_INIT: begin
					if (cnt_q == nm1_q) begin
						cnt_q   <= '0;
						state_q <= ST_INIT_END;
					end else begin
						cnt_q <= cnt_q + VW'(1);
					end
				end
				ST_INIT_END: begin
					found_q <= 1'b0;
					state_q <= ST_SCAN;
				end
				// search for the cheapest crossing edge
				ST_SCAN: begin
					if (cnt_q == nm1_q) begin
						cnt_q   <= '0;
						state_q <= ST_SCAN_END;
					end else begin
						cnt_q <= cnt_q + VW'(1);
					end
				end
				ST_SCAN_END: begin
					state_q <= ST_EMIT;
				end
				// post one result, then relax or finish
				ST_EMIT: begin
					if (res_free) begin
						res_valid_q <= 1'b1;
						if (!found_q) begin
							from_q    <= '0;
							to_q      <= '0;
							weight_q  <= '0;
							disc_q    <= 1'b1;
							last_q    <= 1'b1;
							state_q   <= ST_CLR;
							clr_q     <= '0;
							rewrite_q <= 1'b1;
						end else begin
							from_q            <= VERTEX_W'(pparent_q);
							to_q              <= VERTEX_W'(pick_q);
							weight_q          <= pw_q;
							disc_q            <= 1'b0;
							last_q            <= last_c;
							in_tree_q[pick_q] <= 1'b1;
							joined_q          <= joined_q + VW'(1);
							cnt_q             <= '0;
							if (last_c) begin
								state_q   <= ST_CLR;
								clr_q     <= '0;
								rewrite_q <= 1'b1;
							end else begin
								state_q <= ST_UPD;
							end
						end
					end
				end
				// relax neighbors of the new tree vertex
				ST_UPD: begin
					if (cnt_q == nm1_q) begin
						cnt_q   <= '0;
						state_q <= ST_UPD_END;
					end else begin
						cnt_q <= cnt_q + VW'(1);
					end
				end
				ST_UPD_END: begin
					found_q <= 1'b0;
					state_q <= ST_SCAN;
				end
				// sweep the edge memory clear
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (&clr_q) begin
						cnt_q   <= '0;
						state_q <= rewrite_q ? ST_WR_RD : ST_IDLE;
					end
				end
				// write back tree edges, one vertex at a time
				ST_WR_RD: begin
					state_q <= ST_WR_WR;
				end
				ST_WR_WR: begin
					if (cnt_q == nm1_q) begin
						state_q <= ST_IDLE;
					end else begin
						cnt_q   <= cnt_q + VW'(1);
						state_q <= ST_WR_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// keep the cheapest candidate, lower index wins ties
			if (scan_take) begin
				found_q   <= 1'b1;
				pick_q    <= v_s1;
				pw_q      <= b_weight;
				pparent_q <= b_parent;
			end
		end
	end

	// result ports
	assign res_valid    = res_valid_q;
	assign from_vertex  = from_q;
	assign to_vertex    = to_q;
	assign edge_weight  = weight_q;
	assign disconnected = disc_q;
	assign last         = last_q;

endmodule

### tb/sv/prim_mst_checker.sv
// ----------------------------------------------------------------------------
// prim_mst_checker
// Watches the configuration port, the command channel and the result channel
// of the minimum spanning tree engine. It keeps its own copy of the adjacency
// matrix and register values and grows the tree itself on every accepted
// compute command. Each result transfer is compared field by field against
// the oldest predicted tree edge.
// ----------------------------------------------------------------------------
module prim_mst_checker #(
	parameter int MAX_VERTICES = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [prim_mst_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [prim_mst_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                                 cmd_valid,
	input  logic                                 cmd_ready,
	input  logic [prim_mst_pkg::OPCODE_W-1:0]    opcode,
	input  logic [prim_mst_pkg::VERTEX_W-1:0]    vertex_a,
	input  logic [prim_mst_pkg::VERTEX_W-1:0]    vertex_b,
	input  logic [prim_mst_pkg::WEIGHT_W-1:0]    weight,
	input  logic                                 res_valid,
	input  logic                                 res_ready,
	input  logic [prim_mst_pkg::VERTEX_W-1:0]    from_vertex,
	input  logic [prim_mst_pkg::VERTEX_W-1:0]    to_vertex,
	input  logic [prim_mst_pkg::WEIGHT_W-1:0]    edge_weight,
	input  logic                                 disconnected,
	input  logic                                 last,
	output int unsigned                          outstanding,
	output int unsigned                          fail_count
);
	import prim_mst_pkg::*;

	typedef struct packed {
		logic [VERTEX_W-1:0] src_vertex;
		logic [VERTEX_W-1:0] dst_vertex;
		logic [WEIGHT_W-1:0] weight;
		logic                cut;
		logic                tail;
	} tree_edge_t;

	// bit WEIGHT_W marks an edge as present
	logic [WEIGHT_W:0]   adj [MAX_VERTICES][MAX_VERTICES];
	logic [COUNT_W-1:0]  vertex_count;
	logic [VERTEX_W-1:0] start_vertex;
	tree_edge_t          tree_edges_due [$];
	tree_edge_t          head;
	int unsigned         results_seen;

	initial fail_count = 0;

	task automatic report(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [WEIGHT_W-1:0] got,
			input logic [WEIGHT_W-1:0] want);
		if (got !== want)
			report($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
				results_seen, name, got, want));
	endtask

	function automatic void wipe_matrix();
		for (int r = 0; r < MAX_VERTICES; r++)
			for (int c = 0; c < MAX_VERTICES; c++)
				adj[r][c] = '0;
	endfunction

	// grow the tree from the start vertex and queue one result per chosen edge, or a disconnected result
	function automatic void grow_tree();
		logic [WEIGHT_W:0]   cost [MAX_VERTICES];
		logic [VERTEX_W-1:0] parent [MAX_VERTICES];
		bit                  joined [MAX_VERTICES];
		tree_edge_t          chosen [MAX_VERTICES];
		tree_edge_t          edge_out;
		logic [WEIGHT_W:0]   e;
		int                  n, root, pick, joined_cnt, picked;
		bit                  found;
		n = (vertex_count < 2) ? 2 :
			(vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
		root = (start_vertex >= n) ? n - 1 : int'(start_vertex);
		for (int v = 0; v < MAX_VERTICES; v++) begin
			joined[v] = 1'b0;
			cost[v]   = adj[root][v];
			parent[v] = VERTEX_W'(root);
		end
		joined[root] = 1'b1;
		joined_cnt   = 1;
		picked       = 0;
		pick         = 0;
		while (joined_cnt < n) begin
			// cheapest crossing edge, lower vertex wins ties
			found = 1'b0;
			for (int v = 0; v < n; v++) begin
				if (!joined[v] && cost[v][WEIGHT_W] &&
						(!found || cost[v][WEIGHT_W-1:0] < cost[pick][WEIGHT_W-1:0])) begin
					found = 1'b1;
					pick  = v;
				end
			end
			if (!found) begin
				edge_out = '0;
				edge_out.cut  = 1'b1;
				edge_out.tail = 1'b1;
				tree_edges_due.push_back(edge_out);
				break;
			end
			edge_out.src_vertex = parent[pick];
			edge_out.dst_vertex = VERTEX_W'(pick);
			edge_out.weight     = cost[pick][WEIGHT_W-1:0];
			edge_out.cut        = 1'b0;
			edge_out.tail       = (joined_cnt + 1 == n);
			tree_edges_due.push_back(edge_out);
			chosen[picked] = edge_out;
			picked++;
			joined[pick] = 1'b1;
			joined_cnt++;
			// relax neighbors of the new vertex, lower parent wins ties
			for (int u = 0; u < n; u++) begin
				e = adj[pick][u];
				if (!joined[u] && e[WEIGHT_W] && (!cost[u][WEIGHT_W] ||
						e[WEIGHT_W-1:0] < cost[u][WEIGHT_W-1:0] ||
						(e[WEIGHT_W-1:0] == cost[u][WEIGHT_W-1:0] && pick < parent[u]))) begin
					cost[u]   = e;
					parent[u] = VERTEX_W'(pick);
				end
			end
		end
		// only the chosen tree edges survive the run
		wipe_matrix();
		for (int i = 0; i < picked; i++) begin
			adj[chosen[i].src_vertex][chosen[i].dst_vertex] = {1'b1, chosen[i].weight};
			adj[chosen[i].dst_vertex][chosen[i].src_vertex] = {1'b1, chosen[i].weight};
		end
	endfunction

	// register writes, command transfers and result transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_matrix();
			vertex_count = VERTEX_COUNT_RESET;
			start_vertex = START_VERTEX_RESET;
			results_seen = 0;
			tree_edges_due.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_VERTEX_COUNT: vertex_count = cfg_data[COUNT_W-1:0];
					REG_START_VERTEX: start_vertex = cfg_data[VERTEX_W-1:0];
					default: ;
				endcase
			end
			if (cmd_valid && cmd_ready) begin
				case (opcode_t'(opcode))
					OP_CLEAR: wipe_matrix();
					OP_ADD: begin
						adj[vertex_a][vertex_b] = {1'b1, weight};
						adj[vertex_b][vertex_a] = {1'b1, weight};
					end
					OP_RUN: grow_tree();
					default: ;
				endcase
			end
			if (res_valid && res_ready) begin
				if (tree_edges_due.size() == 0) begin
					report($sformatf("result %0d arrived with none expected", results_seen));
				end else begin
					head = tree_edges_due.pop_front();
					check_field("from_vertex", WEIGHT_W'(from_vertex),
						WEIGHT_W'(head.src_vertex));
					check_field("to_vertex", WEIGHT_W'(to_vertex),
						WEIGHT_W'(head.dst_vertex));
					check_field("edge_weight", edge_weight, head.weight);
					check_field("disconnected", WEIGHT_W'(disconnected),
						WEIGHT_W'(head.cut));
					check_field("last", WEIGHT_W'(last), WEIGHT_W'(head.tail));
				end
				results_seen++;
			end
			outstanding <= tree_edges_due.size();
		end
	end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the minimum spanning tree engine. A directed part
// covers empty, disconnected, self-edge, repeated-edge, tie and out-of-range
// cases; then random phases at several register settings load graphs that
// are mostly spanning and run the tree, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
	import prim_mst_pkg::*;

	localparam int CLK_PERIOD    = 12;
	localparam int ITEM_TARGET   = 210;
	localparam int IDLE_PCT      = 13;
	localparam int SETTLE_CYCLES = 600;
	localparam int MAX_VERTICES  = 16;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   cfg_we       = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;
	logic                   cmd_valid    = 1'b0;
	logic                   cmd_ready;
	opcode_t                opcode       = OP_NONE;
	logic [VERTEX_W-1:0]    vertex_a     = '0;
	logic [VERTEX_W-1:0]    vertex_b     = '0;
	logic [WEIGHT_W-1:0]    weight       = '0;
	logic                   res_valid;
	logic                   res_ready    = 1'b0;
	logic [VERTEX_W-1:0]    from_vertex;
	logic [VERTEX_W-1:0]    to_vertex;
	logic [WEIGHT_W-1:0]    edge_weight;
	logic                   disconnected;
	logic                   last;
	int unsigned            outstanding;
	int unsigned            fail_count;
	bit                     gaps_on      = 1'b1;
	int                     sent_items   = 0;

	prim_minimum_spanning_tree #(.MAX_VERTICES(MAX_VERTICES)) u_dut (.*);

	prim_mst_checker #(.MAX_VERTICES(MAX_VERTICES)) u_checker (.*);

	// clock
	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	// result side stalls at random
	always @(posedge clk) begin
		res_ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
	end

	// one command transfer, with random idle cycles ahead of it
	task automatic send_cmd(input opcode_t op, input logic [VERTEX_W-1:0] a,
			input logic [VERTEX_W-1:0] b, input logic [WEIGHT_W-1:0] w);
		while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		opcode    <= op;
		vertex_a  <= a;
		vertex_b  <= b;
		weight    <= w;
		do @(posedge clk); while (!cmd_ready);
		if (op != OP_NONE)
			sent_items++;
	endtask

	// hold commands until every result is in, then let the engine settle
	task automatic wait_quiet();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input logic [CFG_DATA_W-1:0] count,
			input logic [CFG_DATA_W-1:0] start);
		cfg_we    <= 1'b1;
		cfg_index <= REG_VERTEX_COUNT;
		cfg_data  <= count;
		@(posedge clk);
		cfg_index <= REG_START_VERTEX;
		cfg_data  <= start;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// extremes and small values (ties) are favored
	function automatic logic [WEIGHT_W-1:0] rand_weight();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			2, 3:    return WEIGHT_W'($urandom_range(3));
			default: return WEIGHT_W'($urandom);
		endcase
	endfunction

	// clear, load a mostly spanning graph over a shuffled vertex order, run
	task automatic send_random_sequence(input int n_eff);
		int perm [MAX_VERTICES];
		int i, j, tmp;
		bit full;
		for (i = 0; i < MAX_VERTICES; i++)
			perm[i] = i;
		for (i = n_eff - 1; i > 0; i--) begin
			j       = $urandom_range(i);
			tmp     = perm[i];
			perm[i] = perm[j];
			perm[j] = tmp;
		end
		full = ($urandom_range(4) != 0);
		if ($urandom_range(3) != 0)
			send_cmd(OP_CLEAR, VERTEX_W'($urandom), VERTEX_W'($urandom),
				WEIGHT_W'($urandom));
		// chain each vertex to an earlier one, sometimes leaving gaps
		for (i = 1; i < n_eff; i++) begin
			if (full || $urandom_range(1)) begin
				j = perm[$urandom_range(i - 1)];
				if ($urandom_range(1))
					send_cmd(OP_ADD, VERTEX_W'(perm[i]), VERTEX_W'(j), rand_weight());
				else
					send_cmd(OP_ADD, VERTEX_W'(j), VERTEX_W'(perm[i]), rand_weight());
			end
		end
		// extra edges and noise
		repeat ($urandom_range(n_eff)) begin
			case ($urandom_range(7))
				0:       send_cmd(OP_NONE, VERTEX_W'($urandom), VERTEX_W'($urandom),
						WEIGHT_W'($urandom));
				1:       send_cmd(OP_ADD, VERTEX_W'($urandom), VERTEX_W'($urandom),
						rand_weight());
				default: send_cmd(OP_ADD, VERTEX_W'($urandom_range(n_eff - 1)),
						VERTEX_W'($urandom_range(n_eff - 1)), rand_weight());
			endcase
		end
		send_cmd(OP_RUN, VERTEX_W'($urandom), VERTEX_W'($urandom), WEIGHT_W'($urandom));
		if ($urandom_range(4) == 0)
			send_cmd(OP_RUN, VERTEX_W'($urandom), VERTEX_W'($urandom),
				WEIGHT_W'($urandom));
	endtask

	// main stimulus and verdict
	initial begin
		logic [CFG_DATA_W-1:0] count, start;
		int phase, n_eff;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: empty graph, self edge, repeated edge, unused opcode
		send_cmd(OP_RUN, 4'hf, 4'hf, 16'hffff);
		send_cmd(OP_ADD, 4'd1, 4'd2, 16'hffff);
		send_cmd(OP_ADD, 4'd2, 4'd1, 16'd5);
		send_cmd(OP_ADD, 4'd3, 4'd3, 16'd0);
		send_cmd(OP_ADD, 4'd0, 4'd1, 16'd0);
		send_cmd(OP_ADD, 4'd15, 4'd14, 16'hffff);
		send_cmd(OP_ADD, 4'd1, 4'd15, 16'hffff);
		send_cmd(OP_NONE, 4'hf, 4'hf, 16'hffff);
		send_cmd(OP_RUN, 4'h0, 4'h0, 16'h0000);
		send_cmd(OP_RUN, 4'hf, 4'h0, 16'h00ff);
		send_cmd(OP_CLEAR, 4'hf, 4'hf, 16'hffff);
		send_cmd(OP_RUN, 4'h0, 4'hf, 16'hff00);

		// four vertices, start beyond range, equal weights within range
		wait_quiet();
		write_regs(5'd4, 5'd15);
		send_cmd(OP_ADD, 4'd0, 4'd1, 16'd4);
		send_cmd(OP_ADD, 4'd0, 4'd2, 16'd4);
		send_cmd(OP_ADD, 4'd1, 4'd2, 16'd4);
		send_cmd(OP_ADD, 4'd3, 4'd0, 16'd4);
		send_cmd(OP_ADD, 4'd3, 4'd1, 16'd4);
		send_cmd(OP_ADD, 4'd2, 4'd3, 16'd4);
		send_cmd(OP_ADD, 4'd3, 4'd9, 16'd1);
		send_cmd(OP_RUN, 4'h5, 4'ha, 16'h5a5a);

		// two vertices, whatever tree edges remain
		wait_quiet();
		write_regs(5'd2, 5'd0);
		send_cmd(OP_RUN, 4'ha, 4'h5, 16'ha5a5);

		// random phases, register extremes first
		phase = 0;
		while (sent_items < ITEM_TARGET) begin
			case (phase)
				0: begin count = 5'd2;  start = 5'd0;  end
				1: begin count = 5'd16; start = 5'd15; end
				2: begin count = 5'd31; start = 5'd0;  end
				3: begin count = 5'd0;  start = 5'd1;  end
				4: begin count = 5'd1;  start = 5'd31; end
				default: begin
					count = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom_range(31)) :
						CFG_DATA_W'($urandom_range(2, 8));
					start = CFG_DATA_W'($urandom_range(31));
				end
			endcase
			wait_quiet();
			gaps_on = (phase != 2);
			write_regs(count, start);
			n_eff = (count < 2) ? 2 : (count > MAX_VERTICES) ? MAX_VERTICES : int'(count);
			repeat ($urandom_range(1, 2))
				send_random_sequence(n_eff);
			phase++;
		end

		wait_quiet();
		if (fail_count == 0)
			$display("prim_minimum_spanning_tree: match");
		else
			$display("prim_minimum_spanning_tree: mismatch");
		$finish;
	end

	// hang guard
	initial begin
		#(CLK_PERIOD * 3_000_000);
		$display("prim_minimum_spanning_tree: mismatch");
		$finish;
	end

endmodule
